// ===== rtl/core/dei_pkg.sv =====
// Shared types and constants for the indexed double-ended queue.
package dei_pkg;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_READ       = 2'd2
    } op_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic {
        FSM_IDLE,
        FSM_RESULT
    } fsm_t;

    // Fixed field widths of the stream payloads.
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 112;
    localparam int unsigned TUSER_W  = 2;

    // Control handed from the sequencer to the output stage.
    typedef struct packed {
        logic    load;
        logic    rd_ok;
        status_t status;
    } dei_res_t;

endpackage

// ===== rtl/core/dei_store.sv =====
// Element memory: one write port and one registered read port.
module dei_store
    import dei_pkg::*;
#(
    parameter int unsigned DEPTH      = 256,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write one entry per transaction
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dei_ctrl.sv =====
// Sequencer: pointers, fill count, end copies and memory access generation.
module dei_ctrl
    import dei_pkg::*;
#(
    parameter int unsigned DEPTH      = 256,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [TUSER_W-1:0]         in_op,
    input  logic [VALUE_W-1:0]         in_value,
    input  logic [INDEX_W-1:0]         in_index,
    input  logic                       out_free,
    output logic                       wr_en,
    output logic [$clog2(DEPTH)-1:0]   wr_addr,
    output logic [DATA_WIDTH-1:0]      wr_data,
    output logic                       rd_en,
    output logic [$clog2(DEPTH)-1:0]   rd_addr,
    output dei_res_t                   res,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [DATA_WIDTH-1:0]      front,
    output logic [DATA_WIDTH-1:0]      back
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

    fsm_t              state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    logic              rd_ok_reg, rd_ok_next;
    status_t           status_reg, status_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic [63:0]       value_ext;
    logic [DATA_WIDTH-1:0] value_st;
    logic [AW-1:0]     head_dec;
    logic [SW-1:0]     tail_sum;
    logic [AW-1:0]     tail_pos;
    logic [SW-1:0]     idx_sum;
    logic [AW-1:0]     idx_pos;
    logic              idx_in_range;

    // Trim the signed input to the stored width
    assign value_ext = 64'($signed(in_value));
    assign value_st  = value_ext[DATA_WIDTH-1:0];

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Ring positions: one below head, head plus count, head plus index
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                               : AW'(tail_sum);
    assign idx_in_range = (SW'(in_index) < SW'(count_reg));
    assign idx_sum  = SW'(head_reg) + SW'(in_index);
    assign idx_pos  = (idx_sum >= SW'(DEPTH)) ? AW'(idx_sum - SW'(DEPTH))
                                              : AW'(idx_sum);

    // Hold state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            front_reg  <= '0;
            back_reg   <= '0;
            rd_ok_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            rd_ok_reg  <= rd_ok_next;
            status_reg <= status_next;
        end
    end

    // Decode the transaction and update pointers
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        rd_ok_next  = rd_ok_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        accept      = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = tail_pos;
        wr_data     = value_st;
        rd_en       = 1'b0;
        rd_addr     = idx_pos;
        res.load    = 1'b0;
        res.rd_ok   = rd_ok_reg;
        res.status  = status_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                in_ready = out_free;
                accept   = in_valid && out_free;
                if (accept)
                begin
                    state_next  = FSM_RESULT;
                    rd_ok_next  = 1'b0;
                    status_next = ST_OK;
                    case (op_t'(in_op))
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                front_next = value_st;
                                if (empty)
                                begin
                                    back_next = value_st;
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = tail_pos;
                                back_next = value_st;
                                if (empty)
                                begin
                                    front_next = value_st;
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_ok_next = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            FSM_RESULT:
            begin
                // Read data is valid now; hand the result to the output stage
                res.load   = 1'b1;
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign count = count_reg;
    assign front = front_reg;
    assign back  = back_reg;

endmodule

// ===== rtl/core/double_ended_queue_indexed.sv =====
// Top level of the indexed double-ended queue with its output register.
//
// Double-ended queue in a ring buffer of DEPTH entries of DATA_WIDTH bits.
// Each input transaction pushes a value at the front (operation 0), pushes at
// the back (1) or reads the element at an index from the front (2); code 3
// changes nothing. Every transaction returns one result with read data (zero
// unless a read succeeded), a status (0 ok, 1 index out of range, 2 full and
// push refused), the count after the transaction, an empty flag, and the
// front and back values (zero while empty). Stored values keep the low
// DATA_WIDTH bits and come back sign-extended. The result enters the output
// register in the cycle after acceptance: acceptance updates the pointers and
// registers the memory read, and the result state then loads the output
// register. No new transaction is taken until that result is loaded and the
// output register is free.
// The memory needs no clearing after reset: only written entries are read.
module double_ended_queue_indexed
    import dei_pkg::*;
#(
    parameter int unsigned DEPTH      = 256,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_DW-1:0]    s_tdata,   // value[31:0], index[39:32]
    input  logic [TUSER_W-1:0]  s_tuser,   // operation[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_DW-1:0]   m_tdata,   // read_data[31:0], element_count[40:32],
                                           // is_empty[41], front_value[73:42],
                                           // back_value[105:74], zero[111:106]
    output logic [TUSER_W-1:0]  m_tuser    // status[1:0]
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    dei_res_t              res;
    logic [CW-1:0]         count;
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
    logic                  out_free;

    logic                  m_tvalid_reg;
    logic [OUT_DW-1:0]     m_tdata_reg;
    logic [TUSER_W-1:0]    m_tuser_reg;
    logic [OUT_DW-1:0]     m_tdata_next;

    logic                  empty;
    logic [CW+8:0]         count_ext;
    logic [63:0]           rd_ext;
    logic [63:0]           front_ext;
    logic [63:0]           back_ext;
    logic [VALUE_W-1:0]    rd_field;
    logic [VALUE_W-1:0]    front_field;
    logic [VALUE_W-1:0]    back_field;

    assign out_free = !m_tvalid_reg || m_tready;

    dei_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_value (s_tdata[31:0]),
        .in_index (s_tdata[39:32]),
        .out_free (out_free),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .res      (res),
        .count    (count),
        .front    (front),
        .back     (back)
    );

    dei_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sign-extend stored values into the 32-bit result fields
    assign empty       = (count == '0);
    assign count_ext   = (CW + 9)'(count);
    assign rd_ext      = 64'($signed(rd_data));
    assign front_ext   = 64'($signed(front));
    assign back_ext    = 64'($signed(back));
    assign rd_field    = res.rd_ok ? rd_ext[31:0] : '0;
    assign front_field = empty ? '0 : front_ext[31:0];
    assign back_field  = empty ? '0 : back_ext[31:0];

    // Pack the result payload
    always_comb
    begin
        m_tdata_next          = '0;
        m_tdata_next[31:0]    = rd_field;
        m_tdata_next[40:32]   = count_ext[8:0];
        m_tdata_next[41]      = empty;
        m_tdata_next[73:42]   = front_field;
        m_tdata_next[105:74]  = back_field;
    end

    // Hold the result until the transaction completes downstream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Load the payload
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
